// ===== rtl/core/tid2ts_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile ID to tileset coordinates: shared types and constants
// Payload structures, command and register codes, and the back-end states.
// ----------------------------------------------------------------------------
package tid2ts_pkg;

  localparam int unsigned IdBits   = 16;
  localparam int unsigned DivCntW  = $clog2(IdBits);
  localparam int unsigned PosW     = 10;
  localparam int unsigned MapRegW  = 11;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = QPtrW + 1;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(IdBits - 1);
  localparam logic [MapRegW-1:0] PosLimit = MapRegW'(1 << PosW);

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTile = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgMapColumns   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMapRows      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTilesetCount = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [15:0] tile_id;
    logic [2:0]  slot;
    logic [15:0] first_gid;
    logic [15:0] last_gid;
    logic [15:0] tiles_in_set;
    logic [8:0]  set_columns;
    logic [8:0]  set_tile_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  set_index;
    logic [15:0] src_row;
    logic [7:0]  src_col;
    logic [17:0] dest_x;
    logic [17:0] dest_y;
  } out_item_t;

  typedef struct packed {
    logic [15:0] first_gid;
    logic [15:0] last_gid;
    logic [15:0] tiles;
    logic [8:0]  columns;
    logic [8:0]  tile_size;
  } set_entry_t;

  typedef struct packed {
    logic            cmd;
    logic [15:0]     tile_id;
    logic [2:0]      slot;
    set_entry_t      set_data;
    logic [PosW-1:0] col_pos;
    logic [PosW-1:0] row_pos;
  } qentry_t;

  typedef enum logic [2:0] {
    BsIdle,
    BsRead,
    BsCheck,
    BsDiv,
    BsDone
  } back_state_e;

endpackage

// ===== rtl/core/tile_id_to_tileset_coords_core.sv =====
// ----------------------------------------------------------------------------
// Tile ID to tileset coordinates
// Turns a row-major stream of tile map IDs into tileset slot, source row and
// column, and destination pixel position.
// ----------------------------------------------------------------------------
// Items enter through push and full; an item is a transfer when push is high
// and full is low. Load items fill a tileset slot, tile items present one map
// cell. Results leave through empty and pop; the oldest result sits on
// out_item_o while empty is low and is a transfer when pop is high.
// The configuration registers must be written through cfg_we_i, cfg_idx_i and
// cfg_data_i only while the block is idle; the block does not enforce it.
// The front end places an item in the queue at its transfer edge. A tile item
// is then taken by the back end when idle, which searches the table one slot
// at a time, with a read and a check for each slot and a fallback to slot 0,
// and then runs the 16-step restoring divider before the result appears. The
// back end takes no new item before it has finished the last one.
// Empty tiles and load items give no result.
// A two-entry queue lets the front end take new items while the back end is
// busy, and a stalled receiver holds the back end only once a second result
// is ready. Reset returns the map position to the origin and the registers
// to one; the tileset table holds no valid data until it is loaded.
// ----------------------------------------------------------------------------
module tile_id_to_tileset_coords_core
  import tid2ts_pkg::*;
#(
  parameter int unsigned MAX_SETS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  input  logic                pop,
  output logic                empty,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic              q_push, q_full, q_pop, q_empty, accept;
  qentry_t           q_in, q_out;
  logic [CountW-1:0] tileset_count;

  assign full   = q_full;
  assign accept = push && !q_full;

  tid2ts_front #(
    .MAX_SETS(MAX_SETS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .item_i         (in_item_i),
    .q_push_o       (q_push),
    .q_entry_o      (q_in),
    .tileset_count_o(tileset_count)
  );

  tid2ts_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .entry_o(q_out),
    .empty_o(q_empty)
  );

  tid2ts_back #(
    .MAX_SETS(MAX_SETS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tileset_count_i(tileset_count),
    .q_entry_i      (q_out),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .out_pop_i      (pop),
    .out_empty_o    (empty),
    .out_item_o     (out_item_o)
  );

endmodule

// ===== rtl/core/tid2ts_fifo.sv =====
// ----------------------------------------------------------------------------
// Tile ID to tileset coordinates: work queue
// A short queue that decouples the classifying front end from the back end.
// ----------------------------------------------------------------------------
module tid2ts_fifo
  import tid2ts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qentry_t entry_i,
  output logic    full_o,
  input  logic    pop_i,
  output qentry_t entry_o,
  output logic    empty_o
);

  qentry_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               wr, rd;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign entry_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wr ? wp_q + QPtrW'(1) : wp_q;
    rp_d  = rd ? rp_q + QPtrW'(1) : rp_q;
    cnt_d = cnt_q + QCntW'(wr) - QCntW'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/tid2ts_front.sv =====
// ----------------------------------------------------------------------------
// Tile ID to tileset coordinates: front end
// Holds the configuration registers, tracks the map position and classifies
// incoming items before they enter the work queue.
// ----------------------------------------------------------------------------
module tid2ts_front
  import tid2ts_pkg::*;
#(
  parameter int unsigned MAX_SETS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  in_item_t            item_i,
  output logic                q_push_o,
  output qentry_t             q_entry_o,
  output logic [CountW-1:0]   tileset_count_o
);

  logic [MapRegW-1:0] map_columns_q, map_columns_d;
  logic [MapRegW-1:0] map_rows_q, map_rows_d;
  logic [CountW-1:0]  tileset_count_q, tileset_count_d;
  logic [PosW-1:0]    col_q, col_d, row_q, row_d;
  logic [MapRegW-1:0] next_col, next_row;
  logic               slot_ok, is_tile;

  assign is_tile  = (item_i.cmd == CmdTile);
  assign slot_ok  = ({5'd0, item_i.slot} < 8'(MAX_SETS));
  assign q_push_o = accept_i && (is_tile ? (item_i.tile_id != '0) : slot_ok);
  assign tileset_count_o = tileset_count_q;

  always_comb begin
    q_entry_o                        = '0;
    q_entry_o.cmd                    = item_i.cmd;
    q_entry_o.tile_id                = item_i.tile_id;
    q_entry_o.slot                   = item_i.slot;
    q_entry_o.set_data.first_gid     = item_i.first_gid;
    q_entry_o.set_data.last_gid      = item_i.last_gid;
    q_entry_o.set_data.tiles         = item_i.tiles_in_set;
    q_entry_o.set_data.columns       = item_i.set_columns;
    q_entry_o.set_data.tile_size     = item_i.set_tile_size;
    q_entry_o.col_pos                = col_q;
    q_entry_o.row_pos                = row_q;
  end

  always_comb begin
    map_columns_d   = map_columns_q;
    map_rows_d      = map_rows_q;
    tileset_count_d = tileset_count_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMapColumns:   map_columns_d   = cfg_data_i;
        CfgMapRows:      map_rows_d      = cfg_data_i;
        CfgTilesetCount: tileset_count_d = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    next_col = {1'b0, col_q} + MapRegW'(1);
    next_row = {1'b0, row_q} + MapRegW'(1);
    col_d    = col_q;
    row_d    = row_q;
    if (accept_i && is_tile) begin
      if (next_col >= map_columns_q || next_col >= PosLimit) begin
        col_d = '0;
        if (next_row >= map_rows_q || next_row >= PosLimit) begin
          row_d = '0;
        end else begin
          row_d = next_row[PosW-1:0];
        end
      end else begin
        col_d = next_col[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_columns_q   <= MapRegW'(1);
      map_rows_q      <= MapRegW'(1);
      tileset_count_q <= CountW'(1);
      col_q           <= '0;
      row_q           <= '0;
    end else begin
      map_columns_q   <= map_columns_d;
      map_rows_q      <= map_rows_d;
      tileset_count_q <= tileset_count_d;
      col_q           <= col_d;
      row_q           <= row_d;
    end
  end

endmodule

// ===== rtl/core/tid2ts_back.sv =====
// ----------------------------------------------------------------------------
// Tile ID to tileset coordinates: back end
// Keeps the tileset table, searches it one slot at a time, divides the local
// index with a restoring divider and holds the result for the receiver.
// ----------------------------------------------------------------------------
module tid2ts_back
  import tid2ts_pkg::*;
#(
  parameter int unsigned MAX_SETS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] tileset_count_i,
  input  qentry_t           q_entry_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  input  logic              out_pop_i,
  output logic              out_empty_o,
  output out_item_t         out_item_o
);

  localparam int unsigned SlotW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_SETS + 1);

  back_state_e        state_q, state_d;
  set_entry_t         mem_q [MAX_SETS];
  set_entry_t         rd_q;
  logic [SlotW-1:0]   k_q, k_d, sel_q, sel_d;
  logic [15:0]        id_q, id_d, quo_q, quo_d;
  logic [8:0]         rem_q, rem_d, cols_q, cols_d, size_q, size_d;
  logic [PosW-1:0]    col_q, col_d, row_q, row_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic [CntW-1:0]    count;
  logic               hit, take, out_free, last_slot;
  logic [15:0]        local_idx, minus_one;
  logic [9:0]         trial;
  logic [18:0]        prod_x, prod_y;

  assign q_pop_o     = (state_q == BsIdle) && !q_empty_i;
  assign out_free    = !out_valid_q || out_pop_i;
  assign out_empty_o = !out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    if (tileset_count_i == '0) begin
      count = CntW'(1);
    end else if ({4'd0, tileset_count_i} > 8'(MAX_SETS)) begin
      count = CntW'(MAX_SETS);
    end else begin
      count = CntW'(tileset_count_i);
    end
  end

  assign hit       = (k_q != '0) && (id_q >= rd_q.first_gid) && (id_q <= rd_q.last_gid);
  assign take      = (k_q == '0) || hit;
  assign last_slot = ((CntW'(k_q) + CntW'(1)) >= count);
  assign local_idx = hit ? (id_q + rd_q.tiles - rd_q.last_gid) : id_q;
  assign minus_one = local_idx - 16'd1;
  assign trial     = {rem_q, quo_q[15]};
  assign prod_x    = col_q * size_q;
  assign prod_y    = row_q * size_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BsIdle: begin
        if (!q_empty_i && q_entry_i.cmd == CmdTile) begin
          state_d = BsRead;
        end
      end
      BsRead:  state_d = BsCheck;
      BsCheck: state_d = take ? BsDiv : BsRead;
      BsDiv: begin
        if (dcnt_q == DivLast) begin
          state_d = BsDone;
        end
      end
      BsDone: begin
        if (out_free) begin
          state_d = BsIdle;
        end
      end
      default: state_d = BsIdle;
    endcase
  end

  always_comb begin
    k_d         = k_q;
    sel_d       = sel_q;
    id_d        = id_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cols_d      = cols_q;
    size_d      = size_q;
    col_d       = col_q;
    row_d       = row_q;
    dcnt_d      = dcnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_pop_i;
    case (state_q)
      BsIdle: begin
        if (!q_empty_i && q_entry_i.cmd == CmdTile) begin
          id_d  = q_entry_i.tile_id;
          col_d = q_entry_i.col_pos;
          row_d = q_entry_i.row_pos;
          k_d   = (count > CntW'(1)) ? SlotW'(1) : '0;
        end
      end
      BsCheck: begin
        if (take) begin
          sel_d  = k_q;
          quo_d  = minus_one;
          rem_d  = '0;
          dcnt_d = '0;
          cols_d = (rd_q.columns == '0) ? 9'd1 : rd_q.columns;
          size_d = rd_q.tile_size;
        end else if (last_slot) begin
          k_d = '0;
        end else begin
          k_d = k_q + SlotW'(1);
        end
      end
      BsDiv: begin
        dcnt_d = dcnt_q + DivCntW'(1);
        if (trial >= {1'b0, cols_q}) begin
          rem_d = 9'(trial - {1'b0, cols_q});
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = trial[8:0];
          quo_d = {quo_q[14:0], 1'b0};
        end
      end
      BsDone: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.set_index = 3'(sel_q);
          out_d.src_row   = quo_q;
          out_d.src_col   = rem_q[7:0];
          out_d.dest_x    = prod_x[17:0];
          out_d.dest_y    = prod_y[17:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BsIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    sel_q  <= sel_d;
    id_q   <= id_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    cols_q <= cols_d;
    size_q <= size_d;
    col_q  <= col_d;
    row_q  <= row_d;
    dcnt_q <= dcnt_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_entry_i.cmd == CmdLoad) begin
      mem_q[SlotW'(q_entry_i.slot)] <= q_entry_i.set_data;
    end
    rd_q <= mem_q[k_q];
  end

endmodule
